@@ rtl/quaternion_to_rotation_matrix_defines.svh @@
// ---------------------------------------------------------------------------
// Quaternion to rotation matrix: assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property on every edge outside reset
`define QRM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qrm: assertion failed");
// check that a condition implies a consequence in the same cycle
`define QRM_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("qrm: implication failed");
`else
`define QRM_ASSERT(lbl, clk, rst_n, prop)
`define QRM_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`endif

`endif

@@ rtl/qrm_pkg.sv @@
// ---------------------------------------------------------------------------
// qrm_pkg
// Shared types and matrix entry indexes.
// ---------------------------------------------------------------------------
package qrm_pkg;

    localparam int NUM_ENTRIES = 9;

    // matrix entries, row-major
    localparam int E11 = 0;
    localparam int E12 = 1;
    localparam int E13 = 2;
    localparam int E21 = 3;
    localparam int E22 = 4;
    localparam int E23 = 5;
    localparam int E31 = 6;
    localparam int E32 = 7;
    localparam int E33 = 8;

    // control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        logic zero;     // squared norm is zero: force identity
    } t_ctl;

endpackage

@@ rtl/qrm_in_if.sv @@
// ---------------------------------------------------------------------------
// qrm_in_if
// Quaternion input channel, valid/ready.
// ---------------------------------------------------------------------------
interface qrm_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
    logic signed [W-1:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

@@ rtl/qrm_out_if.sv @@
// ---------------------------------------------------------------------------
// qrm_out_if
// Rotation matrix output channel, valid/ready.
// ---------------------------------------------------------------------------
interface qrm_out_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] row1_col1;
    logic signed [W-1:0] row1_col2;
    logic signed [W-1:0] row1_col3;
    logic signed [W-1:0] row2_col1;
    logic signed [W-1:0] row2_col2;
    logic signed [W-1:0] row2_col3;
    logic signed [W-1:0] row3_col1;
    logic signed [W-1:0] row3_col2;
    logic signed [W-1:0] row3_col3;

    modport source (output valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                    row2_col3, row3_col1, row3_col2, row3_col3, input ready);
    modport sink   (input valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                    row2_col3, row3_col1, row3_col2, row3_col3, output ready);
endinterface

@@ rtl/qrm_prod.sv @@
// ---------------------------------------------------------------------------
// qrm_prod
// Products, squared norm and entry numerators (two register stages).
// ---------------------------------------------------------------------------
module qrm_prod #(
    parameter int W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [W-1:0]       i_x,
    input  logic signed [W-1:0]       i_y,
    input  logic signed [W-1:0]       i_z,
    input  logic signed [W-1:0]       i_w,
    output qrm_pkg::t_ctl             o_ctl,
    output logic [2*W+1:0]            o_den,
    output logic                      o_neg [qrm_pkg::NUM_ENTRIES],
    output logic [2*W+1:0]            o_num [qrm_pkg::NUM_ENTRIES]
);
    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 2;

    logic                 r_v1;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;

    logic signed [NW-1:0] s_xx, s_yy, s_zz, s_ww, s_xy, s_wz, s_xz, s_wy, s_yz, s_wx;
    logic signed [NW-1:0] n_sum [qrm_pkg::NUM_ENTRIES];
    logic [NW-1:0]        n_den;

    qrm_pkg::t_ctl        r_ctl;
    logic [NW-1:0]        r_den;
    logic                 r_neg [qrm_pkg::NUM_ENTRIES];
    logic [NW-1:0]        r_num [qrm_pkg::NUM_ENTRIES];

    // stage 1: the ten products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_ww <= i_w * i_w;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_xz <= i_x * i_z;
            r_wy <= i_w * i_y;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
        end
    end

    // stage 2: signed numerators, off-diagonal ones doubled
    always_comb begin
        s_xx = NW'(r_xx);
        s_yy = NW'(r_yy);
        s_zz = NW'(r_zz);
        s_ww = NW'(r_ww);
        s_xy = NW'(r_xy);
        s_wz = NW'(r_wz);
        s_xz = NW'(r_xz);
        s_wy = NW'(r_wy);
        s_yz = NW'(r_yz);
        s_wx = NW'(r_wx);
        n_den = NW'(s_xx + s_yy + s_zz + s_ww);
        n_sum[qrm_pkg::E11] = s_xx + s_ww - s_yy - s_zz;
        n_sum[qrm_pkg::E22] = s_yy + s_ww - s_xx - s_zz;
        n_sum[qrm_pkg::E33] = s_zz + s_ww - s_xx - s_yy;
        n_sum[qrm_pkg::E12] = (s_xy - s_wz) <<< 1;
        n_sum[qrm_pkg::E13] = (s_xz + s_wy) <<< 1;
        n_sum[qrm_pkg::E21] = (s_xy + s_wz) <<< 1;
        n_sum[qrm_pkg::E23] = (s_yz - s_wx) <<< 1;
        n_sum[qrm_pkg::E31] = (s_xz - s_wy) <<< 1;
        n_sum[qrm_pkg::E32] = (s_yz + s_wx) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.zero <= (n_den == '0);
            r_den      <= n_den;
            for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
                r_neg[k] <= n_sum[k][NW-1];
                r_num[k] <= n_sum[k][NW-1] ? NW'(-n_sum[k]) : NW'(n_sum[k]);
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_neg = r_neg;
    assign o_num = r_num;
endmodule

@@ rtl/qrm_div_step.sv @@
// ---------------------------------------------------------------------------
// qrm_div_step
// One restoring division step for all nine entries, registered.
// ---------------------------------------------------------------------------
module qrm_div_step #(
    parameter int W     = 16,
    parameter int F     = 14,
    parameter bit FIRST = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  qrm_pkg::t_ctl    i_ctl,
    input  logic [2*W+1:0]   i_den,
    input  logic             i_neg [qrm_pkg::NUM_ENTRIES],
    input  logic [2*W+1:0]   i_rem [qrm_pkg::NUM_ENTRIES],
    input  logic [F:0]       i_quo [qrm_pkg::NUM_ENTRIES],
    output qrm_pkg::t_ctl    o_ctl,
    output logic [2*W+1:0]   o_den,
    output logic             o_neg [qrm_pkg::NUM_ENTRIES],
    output logic [2*W+1:0]   o_rem [qrm_pkg::NUM_ENTRIES],
    output logic [F:0]       o_quo [qrm_pkg::NUM_ENTRIES]
);
    localparam int NW = 2 * W + 2;
    localparam int QW = F + 1;

    logic [NW-1:0] sh    [qrm_pkg::NUM_ENTRIES];
    logic          ge    [qrm_pkg::NUM_ENTRIES];
    logic [NW-1:0] n_rem [qrm_pkg::NUM_ENTRIES];
    logic [QW-1:0] n_quo [qrm_pkg::NUM_ENTRIES];

    qrm_pkg::t_ctl r_ctl;
    logic [NW-1:0] r_den;
    logic          r_neg [qrm_pkg::NUM_ENTRIES];
    logic [NW-1:0] r_rem [qrm_pkg::NUM_ENTRIES];
    logic [QW-1:0] r_quo [qrm_pkg::NUM_ENTRIES];

    // shift in the next numerator bit position, subtract when it fits
    always_comb begin
        for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
            sh[k]    = FIRST ? i_rem[k] : {i_rem[k][NW-2:0], 1'b0};
            ge[k]    = (sh[k] >= i_den);
            n_rem[k] = ge[k] ? sh[k] - i_den : sh[k];
            n_quo[k] = {i_quo[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.zero <= i_ctl.zero;
            r_den      <= i_den;
            r_neg      <= i_neg;
            r_rem      <= n_rem;
            r_quo      <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_neg = r_neg;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule

@@ rtl/qrm_round.sv @@
// ---------------------------------------------------------------------------
// qrm_round
// Round to nearest, apply sign, saturate; output register.
// ---------------------------------------------------------------------------
module qrm_round #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  qrm_pkg::t_ctl       i_ctl,
    input  logic [2*W+1:0]      i_den,
    input  logic                i_neg [qrm_pkg::NUM_ENTRIES],
    input  logic [2*W+1:0]      i_rem [qrm_pkg::NUM_ENTRIES],
    input  logic [F:0]          i_quo [qrm_pkg::NUM_ENTRIES],
    output logic                o_valid,
    output logic signed [W-1:0] o_ent [qrm_pkg::NUM_ENTRIES]
);
    localparam int QW = F + 1;
    localparam int EW = ((QW > W) ? QW : W) + 1;
    localparam logic [EW-1:0] MAX_MAG = EW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [EW-1:0] MIN_MAG = EW'(64'd1 << (W - 1));

    logic          rnd [qrm_pkg::NUM_ENTRIES];
    logic [QW-1:0] q   [qrm_pkg::NUM_ENTRIES];
    logic          ng  [qrm_pkg::NUM_ENTRIES];
    logic [EW-1:0] qe  [qrm_pkg::NUM_ENTRIES];
    logic signed [W-1:0] n_ent [qrm_pkg::NUM_ENTRIES];

    logic                r_valid;
    logic signed [W-1:0] r_ent [qrm_pkg::NUM_ENTRIES];

    always_comb begin
        for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
            rnd[k] = ({i_rem[k], 1'b0} >= {1'b0, i_den});
            q[k]   = i_quo[k] + QW'(rnd[k]);
            ng[k]  = i_neg[k];
            // zero norm: identity matrix
            if (i_ctl.zero) begin
                ng[k] = 1'b0;
                if (k == qrm_pkg::E11 || k == qrm_pkg::E22 || k == qrm_pkg::E33) begin
                    q[k] = QW'(1) << F;
                end else begin
                    q[k] = '0;
                end
            end
            qe[k] = EW'(q[k]);
            if (ng[k]) begin
                n_ent[k] = (qe[k] > MIN_MAG) ? W'(MIN_MAG) : W'(-qe[k]);
            end else begin
                n_ent[k] = (qe[k] > MAX_MAG) ? W'(MAX_MAG) : W'(qe[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ent <= n_ent;
        end
    end

    assign o_valid = r_valid;
    assign o_ent   = r_ent;
endmodule

@@ rtl/quaternion_to_rotation_matrix.sv @@
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Quaternion (Q2.14) to 3x3 rotation matrix with s = 2 / |q|^2, rounded to
// nearest (ties away from zero) and saturated. Zero quaternion gives identity.
// ---------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------
//  i_quat    | in        | quat_x, quat_y, quat_z, quat_w
//  o_mat     | out       | row1_col1 .. row3_col3 (row-major)
//
//  One transfer in and one out per cycle, sustained while o_mat is not stalled.
//  The pipeline is two stages of products and sums, one restoring division
//  step per quotient bit (FRAC_BITS + 1 stages, nine dividers side by side)
//  and one rounding/output stage.
//  Reset clears the stage valid bits only; payload registers are not reset.
//  A stall on o_mat freezes the whole pipeline; i_quat.ready drops with it.
// ---------------------------------------------------------------------------
`include "quaternion_to_rotation_matrix_defines.svh"

module quaternion_to_rotation_matrix #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrm_in_if.sink    i_quat,
    qrm_out_if.source o_mat
);
    localparam int NW = 2 * DATA_WIDTH + 2;   // remainder / denominator width
    localparam int QW = FRAC_BITS + 1;        // quotient width, also step count

    // pipeline advances whenever the output register is empty or drained
    logic w_en;

    // stage k output feeds division step k; index QW is the last step's output
    qrm_pkg::t_ctl w_ctl [QW+1];
    logic [NW-1:0] w_den [QW+1];
    logic          w_neg [QW+1][qrm_pkg::NUM_ENTRIES];
    logic [NW-1:0] w_rem [QW+1][qrm_pkg::NUM_ENTRIES];
    logic [QW-1:0] w_quo [QW+1][qrm_pkg::NUM_ENTRIES];

    logic                         w_valid;
    logic signed [DATA_WIDTH-1:0] w_ent [qrm_pkg::NUM_ENTRIES];

    assign w_en         = !o_mat.valid || o_mat.ready;
    assign i_quat.ready = w_en;

    // products, squared norm, numerators
    qrm_prod #(
        .W (DATA_WIDTH)
    ) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_quat.valid),
        .i_x     (i_quat.quat_x),
        .i_y     (i_quat.quat_y),
        .i_z     (i_quat.quat_z),
        .i_w     (i_quat.quat_w),
        .o_ctl   (w_ctl[0]),
        .o_den   (w_den[0]),
        .o_neg   (w_neg[0]),
        .o_num   (w_rem[0])
    );

    // quotient starts empty
    always_comb begin
        for (int k = 0; k < qrm_pkg::NUM_ENTRIES; k++) begin
            w_quo[0][k] = '0;
        end
    end

    // one quotient bit per stage, integer bit first
    for (genvar s = 0; s < QW; s++) begin : g_div
        qrm_div_step #(
            .W     (DATA_WIDTH),
            .F     (FRAC_BITS),
            .FIRST (s == 0)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[s]),
            .i_den   (w_den[s]),
            .i_neg   (w_neg[s]),
            .i_rem   (w_rem[s]),
            .i_quo   (w_quo[s]),
            .o_ctl   (w_ctl[s+1]),
            .o_den   (w_den[s+1]),
            .o_neg   (w_neg[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_quo   (w_quo[s+1])
        );
    end

    // round, sign, saturate into the output register
    qrm_round #(
        .W (DATA_WIDTH),
        .F (FRAC_BITS)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl[QW]),
        .i_den   (w_den[QW]),
        .i_neg   (w_neg[QW]),
        .i_rem   (w_rem[QW]),
        .i_quo   (w_quo[QW]),
        .o_valid (w_valid),
        .o_ent   (w_ent)
    );

    assign o_mat.valid     = w_valid;
    assign o_mat.row1_col1 = w_ent[qrm_pkg::E11];
    assign o_mat.row1_col2 = w_ent[qrm_pkg::E12];
    assign o_mat.row1_col3 = w_ent[qrm_pkg::E13];
    assign o_mat.row2_col1 = w_ent[qrm_pkg::E21];
    assign o_mat.row2_col2 = w_ent[qrm_pkg::E22];
    assign o_mat.row2_col3 = w_ent[qrm_pkg::E23];
    assign o_mat.row3_col1 = w_ent[qrm_pkg::E31];
    assign o_mat.row3_col2 = w_ent[qrm_pkg::E32];
    assign o_mat.row3_col3 = w_ent[qrm_pkg::E33];

    // input side stalls exactly when the output register is full and held
    `QRM_ASSERT(a_ready_follows_out, i_clk, i_rst_n, i_quat.ready == (!o_mat.valid || o_mat.ready))
    // zero flag tracks the squared norm it was made from
    `QRM_ASSERT_IMPL(a_zero_flag, i_clk, i_rst_n, w_ctl[0].valid, w_ctl[0].zero == (w_den[0] == '0))
    // after the last step the remainders of the first and last entries stay below the divisor
    `QRM_ASSERT_IMPL(a_rem_first, i_clk, i_rst_n, w_ctl[QW].valid && !w_ctl[QW].zero, w_rem[QW][qrm_pkg::E11] < w_den[QW])
    `QRM_ASSERT_IMPL(a_rem_last, i_clk, i_rst_n, w_ctl[QW].valid && !w_ctl[QW].zero, w_rem[QW][qrm_pkg::E33] < w_den[QW])
endmodule
